// ===== rtl/smt_pkg.sv =====
// Shared constants, types and codes for the sparse matrix transpose core.
package smt_pkg;

    localparam int MAX_ENTRIES  = 1024;
    localparam int MAX_FEATURES = 256;
    localparam int MAX_VECTORS  = 1024;

    localparam int VALUE_W = 32;
    localparam int FEAT_W  = 8;
    localparam int VEC_W   = 10;
    localparam int ENT_AW  = 10;
    localparam int CNT_W   = 11;
    localparam int NF_W    = 9;
    localparam int NV_W    = 11;
    localparam int CELL_W  = VEC_W + FEAT_W + VALUE_W;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] HSEL_FEAT = 2'd0;
    localparam logic [1:0] HSEL_IDX  = 2'd1;
    localparam logic [1:0] HSEL_CELL = 2'd2;

    localparam logic REG_NUM_FEATURES = 1'b0;
    localparam logic REG_NUM_VECTORS  = 1'b1;

    typedef struct packed {
        logic [VEC_W-1:0]   column;
        logic [FEAT_W-1:0]  row;
        logic [VALUE_W-1:0] value;
    } t_cell;

    typedef struct packed {
        logic       capture;
        logic       clr_init;
        logic       clr_wr;
        logic       ld_drop;
        logic       ld_wr;
        logic       pf_init;
        logic       pf_wr;
        logic       sc_ptr;
        logic       sc_wr;
        logic       set_ready;
        logic       f_cell;
        logic       f_nrow;
        logic       f_emit;
        logic       f_empty;
        logic       t_rd_next;
        logic [1:0] hist_rsel;
    } t_cmd;

    typedef struct packed {
        logic drop_cond;
        logic feat_last;
        logic sc_done;
        logic f_empty;
        logic ready;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/smt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/smt_ctrl.sv =====
// Sequencer for clear sweep, load, prefix pass, scatter pass and fetch.
module smt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_opcode,
    input  smt_pkg::t_status i_st,
    output logic           o_in_ready,
    output smt_pkg::t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_LD_CHK = 4'd2;
    localparam logic [3:0] S_LD_WR  = 4'd3;
    localparam logic [3:0] S_PF_RD  = 4'd4;
    localparam logic [3:0] S_PF_WR  = 4'd5;
    localparam logic [3:0] S_SC_RD  = 4'd6;
    localparam logic [3:0] S_SC_PTR = 4'd7;
    localparam logic [3:0] S_SC_WR  = 4'd8;
    localparam logic [3:0] S_F_RD0  = 4'd9;
    localparam logic [3:0] S_F_RD1  = 4'd10;
    localparam logic [3:0] S_F_HIST = 4'd11;
    localparam logic [3:0] S_F_EMIT = 4'd12;
    localparam logic [3:0] S_F_NONE = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.hist_rsel = smt_pkg::HSEL_FEAT;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_opcode)
                        smt_pkg::OP_CLEAR: begin
                            o_cmd.clr_init = 1'b1;
                            n_state = S_CLR;
                        end
                        smt_pkg::OP_LOAD: n_state = S_LD_CHK;
                        smt_pkg::OP_FETCH: begin
                            if (i_st.ready) begin
                                n_state = S_F_RD0;
                            end else begin
                                o_cmd.pf_init = 1'b1;
                                n_state = S_PF_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_st.feat_last) n_state = S_IDLE;
            end
            S_LD_CHK: begin
                if (i_st.drop_cond) begin
                    o_cmd.ld_drop = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LD_WR;
                end
            end
            S_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_PF_RD: begin
                o_cmd.hist_rsel = smt_pkg::HSEL_IDX;
                n_state = S_PF_WR;
            end
            S_PF_WR: begin
                o_cmd.hist_rsel = smt_pkg::HSEL_IDX;
                o_cmd.pf_wr = 1'b1;
                n_state = i_st.feat_last ? S_SC_RD : S_PF_RD;
            end
            S_SC_RD: begin
                if (i_st.sc_done) begin
                    o_cmd.set_ready = 1'b1;
                    n_state = S_F_RD0;
                end else begin
                    n_state = S_SC_PTR;
                end
            end
            S_SC_PTR: begin
                o_cmd.sc_ptr = 1'b1;
                n_state = S_SC_WR;
            end
            S_SC_WR: begin
                o_cmd.sc_wr = 1'b1;
                n_state = S_SC_RD;
            end
            S_F_RD0: n_state = i_st.f_empty ? S_F_NONE : S_F_RD1;
            S_F_RD1: begin
                o_cmd.f_cell = 1'b1;
                o_cmd.t_rd_next = 1'b1;
                n_state = S_F_HIST;
            end
            S_F_HIST: begin
                o_cmd.f_nrow = 1'b1;
                o_cmd.hist_rsel = smt_pkg::HSEL_CELL;
                n_state = S_F_EMIT;
            end
            S_F_EMIT: begin
                o_cmd.hist_rsel = smt_pkg::HSEL_CELL;
                if (i_st.out_free) begin
                    o_cmd.f_emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_F_NONE: begin
                if (i_st.out_free) begin
                    o_cmd.f_empty = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_emit_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.f_emit |-> $past(r_state) == S_F_HIST || $past(r_state) == S_F_EMIT)
        else $error("emit outside fetch sequence");
    a_sweep_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_init |=> r_state == S_CLR)
        else $error("clear did not start sweep");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_cmd.ld_wr && !o_cmd.sc_wr)
        else $error("store write while idle");
endmodule

// ===== rtl/smt_dpath.sv =====
// Stores, histogram, pointers, counters and output register.
module smt_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  smt_pkg::t_cmd               i_cmd,
    output smt_pkg::t_status            o_st,
    input  logic [smt_pkg::NF_W-1:0]    i_num_features,
    input  logic [smt_pkg::NV_W-1:0]    i_num_vectors,
    input  logic [smt_pkg::VEC_W-1:0]   i_vector_index,
    input  logic [smt_pkg::FEAT_W-1:0]  i_feature_index,
    input  logic [smt_pkg::VALUE_W-1:0] i_entry_value,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [smt_pkg::FEAT_W-1:0]  o_out_row,
    output logic [smt_pkg::VEC_W-1:0]   o_out_column,
    output logic [smt_pkg::VALUE_W-1:0] o_out_value,
    output logic [smt_pkg::CNT_W-1:0]   o_row_length,
    output logic                        o_row_end,
    output logic                        o_matrix_end,
    output logic                        o_status,
    output logic                        o_dropped
);
    localparam int FA_W   = smt_pkg::FEAT_W;
    localparam int EA_W   = smt_pkg::ENT_AW;
    localparam int C_W    = smt_pkg::CNT_W;
    localparam int NF_EXT = smt_pkg::NF_W;

    // control state
    logic [C_W-1:0] r_count, r_rp, r_idx, r_sum;
    logic           r_ready, r_drop, r_ovalid;
    // payload
    logic [smt_pkg::VEC_W-1:0]   r_vi;
    logic [FA_W-1:0]             r_fi;
    logic [smt_pkg::VALUE_W-1:0] r_val;
    smt_pkg::t_cell              r_cell;
    logic [FA_W-1:0]             r_nrow;
    logic [FA_W-1:0]             r_o_row;
    logic [smt_pkg::VEC_W-1:0]   r_o_col;
    logic [smt_pkg::VALUE_W-1:0] r_o_val;
    logic [C_W-1:0]              r_o_len;
    logic                        r_o_rend, r_o_mend, r_o_stat, r_o_drop;

    logic [C_W-1:0]  hist_rdata, ptr_rdata, hist_wdata, ptr_wdata;
    logic [FA_W-1:0] hist_raddr, hist_waddr, ptr_waddr;
    logic            hist_we, ptr_we;
    logic [smt_pkg::CELL_W-1:0] e_rdata_raw, t_rdata_raw;
    smt_pkg::t_cell  e_rdata, t_rdata, in_cell;
    logic [EA_W-1:0] t_raddr;
    logic [NF_EXT-1:0] nf_eff;
    logic [smt_pkg::NV_W-1:0] nv_eff;
    logic [C_W-1:0]  rp_inc;
    logic            last;

    assign e_rdata = smt_pkg::t_cell'(e_rdata_raw);
    assign t_rdata = smt_pkg::t_cell'(t_rdata_raw);
    assign in_cell = '{column: r_vi, row: r_fi, value: r_val};

    always_comb begin
        unique case (i_cmd.hist_rsel)
            smt_pkg::HSEL_IDX:  hist_raddr = r_idx[FA_W-1:0];
            smt_pkg::HSEL_CELL: hist_raddr = r_cell.row;
            default:            hist_raddr = r_fi;
        endcase
    end

    assign hist_we    = i_cmd.clr_wr | i_cmd.ld_wr;
    assign hist_waddr = i_cmd.clr_wr ? r_idx[FA_W-1:0] : r_fi;
    assign hist_wdata = i_cmd.clr_wr ? '0 : hist_rdata + C_W'(1);
    assign ptr_we     = i_cmd.pf_wr | i_cmd.sc_wr;
    assign ptr_waddr  = i_cmd.pf_wr ? r_idx[FA_W-1:0] : r_cell.row;
    assign ptr_wdata  = i_cmd.pf_wr ? r_sum : ptr_rdata + C_W'(1);
    assign rp_inc     = r_rp + C_W'(1);
    assign t_raddr    = i_cmd.t_rd_next ? rp_inc[EA_W-1:0] : r_rp[EA_W-1:0];
    assign last       = (rp_inc >= r_count);

    smt_ram #(.WIDTH(C_W), .DEPTH(smt_pkg::MAX_FEATURES)) u_hist (
        .i_clk(i_clk), .i_we(hist_we), .i_waddr(hist_waddr), .i_wdata(hist_wdata),
        .i_raddr(hist_raddr), .o_rdata(hist_rdata));

    smt_ram #(.WIDTH(C_W), .DEPTH(smt_pkg::MAX_FEATURES)) u_ptr (
        .i_clk(i_clk), .i_we(ptr_we), .i_waddr(ptr_waddr), .i_wdata(ptr_wdata),
        .i_raddr(e_rdata.row), .o_rdata(ptr_rdata));

    smt_ram #(.WIDTH(smt_pkg::CELL_W), .DEPTH(smt_pkg::MAX_ENTRIES)) u_entry (
        .i_clk(i_clk), .i_we(i_cmd.ld_wr), .i_waddr(r_count[EA_W-1:0]),
        .i_wdata(in_cell), .i_raddr(r_idx[EA_W-1:0]), .o_rdata(e_rdata_raw));

    smt_ram #(.WIDTH(smt_pkg::CELL_W), .DEPTH(smt_pkg::MAX_ENTRIES)) u_trans (
        .i_clk(i_clk), .i_we(i_cmd.sc_wr), .i_waddr(ptr_rdata[EA_W-1:0]),
        .i_wdata(r_cell), .i_raddr(t_raddr), .o_rdata(t_rdata_raw));

    // clamp register values to capacity
    assign nf_eff = (i_num_features > NF_EXT'(smt_pkg::MAX_FEATURES))
                    ? NF_EXT'(smt_pkg::MAX_FEATURES) : i_num_features;
    assign nv_eff = (i_num_vectors > smt_pkg::NV_W'(smt_pkg::MAX_VECTORS))
                    ? smt_pkg::NV_W'(smt_pkg::MAX_VECTORS) : i_num_vectors;

    assign o_st.drop_cond = r_ready || ({1'b0, r_fi} >= nf_eff)
                            || ({1'b0, r_vi} >= nv_eff)
                            || (r_count >= C_W'(smt_pkg::MAX_ENTRIES));
    assign o_st.feat_last = (r_idx[FA_W-1:0] == FA_W'(smt_pkg::MAX_FEATURES - 1));
    assign o_st.sc_done   = (r_idx >= r_count);
    assign o_st.f_empty   = (r_rp >= r_count);
    assign o_st.ready     = r_ready;
    assign o_st.out_free  = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rp     <= '0;
            r_idx    <= '0;
            r_sum    <= '0;
            r_ready  <= 1'b0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_init) begin
                r_count <= '0;
                r_rp    <= '0;
                r_idx   <= '0;
                r_ready <= 1'b0;
                r_drop  <= 1'b0;
            end
            if (i_cmd.clr_wr) r_idx <= o_st.feat_last ? '0 : r_idx + C_W'(1);
            if (i_cmd.ld_drop) r_drop <= 1'b1;
            if (i_cmd.ld_wr) r_count <= r_count + C_W'(1);
            if (i_cmd.pf_init) begin
                r_idx <= '0;
                r_sum <= '0;
            end
            if (i_cmd.pf_wr) begin
                r_sum <= r_sum + hist_rdata;
                r_idx <= o_st.feat_last ? '0 : r_idx + C_W'(1);
            end
            if (i_cmd.sc_wr) r_idx <= r_idx + C_W'(1);
            if (i_cmd.set_ready) r_ready <= 1'b1;
            if (i_cmd.f_emit) r_rp <= rp_inc;
            if (i_cmd.f_emit || i_cmd.f_empty) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_vi  <= i_vector_index;
            r_fi  <= i_feature_index;
            r_val <= i_entry_value;
        end
        if (i_cmd.sc_ptr) r_cell <= e_rdata;
        if (i_cmd.f_cell) r_cell <= t_rdata;
        if (i_cmd.f_nrow) r_nrow <= t_rdata.row;
        if (i_cmd.f_emit) begin
            r_o_row  <= r_cell.row;
            r_o_col  <= r_cell.column;
            r_o_val  <= r_cell.value;
            r_o_len  <= hist_rdata;
            r_o_rend <= last || (r_nrow != r_cell.row);
            r_o_mend <= last;
            r_o_stat <= 1'b0;
            r_o_drop <= r_drop;
        end else if (i_cmd.f_empty) begin
            r_o_row  <= '0;
            r_o_col  <= '0;
            r_o_val  <= '0;
            r_o_len  <= '0;
            r_o_rend <= 1'b0;
            r_o_mend <= 1'b0;
            r_o_stat <= 1'b1;
            r_o_drop <= r_drop;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_row    = r_o_row;
    assign o_out_column = r_o_col;
    assign o_out_value  = r_o_val;
    assign o_row_length = r_o_len;
    assign o_row_end    = r_o_rend;
    assign o_matrix_end = r_o_mend;
    assign o_status     = r_o_stat;
    assign o_dropped    = r_o_drop;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_W'(smt_pkg::MAX_ENTRIES))
        else $error("entry count above capacity");
    a_rp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_count)
        else $error("read pointer beyond entry count");
    a_no_load_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_wr |-> !r_ready)
        else $error("load stored after transposition");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> r_ovalid && $stable(r_o_val))
        else $error("pending result lost");
endmodule

// ===== rtl/sparse_matrix_transpose_core.sv =====
// Sparse matrix transpose core: top level with configuration registers.
// Clear: histogram sweep of 256 entries; also runs after reset.
// Load: capture, check, store. Fetch: read an entry, look up its row length, emit it, or
// emit a status when no entries are left; a waiting result stalls the fetch until it is taken.
// First fetch after loading runs the prefix-sum pass, then the scatter of stored entries.
// Reset is synchronous, active low; no item is taken until the reset sweep ends.
module sparse_matrix_transpose_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_opcode,
    input  logic [smt_pkg::VEC_W-1:0]   i_vector_index,
    input  logic [smt_pkg::FEAT_W-1:0]  i_feature_index,
    input  logic [smt_pkg::VALUE_W-1:0] i_entry_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [smt_pkg::FEAT_W-1:0]  o_out_row,
    output logic [smt_pkg::VEC_W-1:0]   o_out_column,
    output logic [smt_pkg::VALUE_W-1:0] o_out_value,
    output logic [smt_pkg::CNT_W-1:0]   o_row_length,
    output logic                        o_row_end,
    output logic                        o_matrix_end,
    output logic                        o_status,
    output logic                        o_dropped
);
    logic [smt_pkg::NF_W-1:0] r_num_features;
    logic [smt_pkg::NV_W-1:0] r_num_vectors;
    logic                     wr_en;
    smt_pkg::t_cmd            cmd;
    smt_pkg::t_status         st;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_features <= smt_pkg::NF_W'(smt_pkg::MAX_FEATURES);
            r_num_vectors  <= smt_pkg::NV_W'(smt_pkg::MAX_VECTORS);
        end else if (wr_en) begin
            if (paddr[2] == smt_pkg::REG_NUM_FEATURES) begin
                r_num_features <= pwdata[smt_pkg::NF_W-1:0];
            end else begin
                r_num_vectors <= pwdata[smt_pkg::NV_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == smt_pkg::REG_NUM_VECTORS)
                    ? {21'd0, r_num_vectors} : {23'd0, r_num_features};

    smt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_opcode(i_opcode), .i_st(st), .o_in_ready(o_in_ready), .o_cmd(cmd));

    smt_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_st(st),
        .i_num_features(r_num_features), .i_num_vectors(r_num_vectors),
        .i_vector_index(i_vector_index), .i_feature_index(i_feature_index),
        .i_entry_value(i_entry_value), .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid), .o_out_row(o_out_row), .o_out_column(o_out_column),
        .o_out_value(o_out_value), .o_row_length(o_row_length), .o_row_end(o_row_end),
        .o_matrix_end(o_matrix_end), .o_status(o_status), .o_dropped(o_dropped));
endmodule
